[hw/rtl/periodic_neighbour_cell_ids_assert.svh]
// Assertion macros shared by the periodic neighbour cell block.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef PERIODIC_NEIGHBOUR_CELL_IDS_ASSERT_SVH
`define PERIODIC_NEIGHBOUR_CELL_IDS_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define PNCI_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define PNCI_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define PNCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pnci_pkg.sv]
`timescale 1ns / 1ps

package pnci_pkg;

    localparam int CELL_W    = 24;
    localparam int CFG_W     = 9;
    localparam int POS_W     = 8;
    localparam int SLOT_W    = 5;
    localparam int DIV_STEPS = CELL_W / 2;
    localparam int STEP_W    = 4;

    localparam logic [CFG_W-1:0] CELLS_MIN = 9'd3;
    localparam logic [CFG_W-1:0] CELLS_MAX = 9'd256;

    // Offset codes of one neighbour digit.
    localparam logic [1:0] DIGIT_MINUS = 2'd0;
    localparam logic [1:0] DIGIT_ZERO  = 2'd1;
    localparam logic [1:0] DIGIT_PLUS  = 2'd2;

    typedef enum logic [1:0] {
        CFG_CELLS_A = 2'd0,
        CFG_CELLS_B = 2'd1,
        CFG_CELLS_C = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_DIV,
        DEC_HOLD
    } dec_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] cells_a;
        logic [CFG_W-1:0] cells_b;
        logic [CFG_W-1:0] cells_c;
    } pnci_cfg_t;

    typedef struct packed {
        logic             valid;
        logic             err;
        logic [POS_W-1:0] pos0;
        logic [POS_W-1:0] pos1;
        logic [POS_W-1:0] pos2;
    } pnci_coord_t;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] nbr_id;
        logic [SLOT_W-1:0] slot;
        logic              err;
        logic              last;
    } pnci_result_t;

    // Applies an offset code to one coordinate with periodic wrap.
    function automatic logic [POS_W-1:0] pnci_wrap(
        input logic [POS_W-1:0] pos,
        input logic [1:0]       dig,
        input logic [CFG_W-1:0] size
    );
        logic [CFG_W:0] sum;
        logic [CFG_W:0] np;
        sum = {2'b00, pos} + {8'b0, dig};
        if (sum == '0)
            np = {1'b0, size} - 10'd1;
        else
            np = sum - 10'd1;
        if (np >= {1'b0, size})
            np = np - {1'b0, size};
        return np[POS_W-1:0];
    endfunction

endpackage

[hw/rtl/pnci_decode.sv]
`timescale 1ns / 1ps

module pnci_decode
    import pnci_pkg::*;
#(
    parameter int DIMENSIONS = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pnci_cfg_t         cfg,
    input  logic              load,
    input  logic [CELL_W-1:0] home,
    output logic              ready,
    input  logic              take,
    output pnci_coord_t       coord
);

    localparam logic [1:0] FIRST_AXIS = 2'(DIMENSIONS - 1);

    dec_state_t        state_reg;
    dec_state_t        state_next;
    logic [CELL_W-1:0] quot_reg;
    logic [POS_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [1:0]        axis_reg;
    logic [POS_W-1:0]  pos0_reg;
    logic [POS_W-1:0]  pos1_reg;
    logic [POS_W-1:0]  pos2_reg;
    logic              err_reg;

    logic [CFG_W-1:0]  divisor;
    logic [CFG_W-1:0]  part_a;
    logic [CFG_W-1:0]  part_a_sub;
    logic [CFG_W-1:0]  part_b;
    logic [CFG_W-1:0]  part_b_sub;
    logic              bit_a;
    logic              bit_b;
    logic [POS_W-1:0]  rem_new;
    logic [CELL_W-1:0] quot_new;
    logic              step_done;

    // Two restoring quotient bits per cycle.
    always_comb
    begin
        divisor    = (axis_reg == 2'd2) ? cfg.cells_c : cfg.cells_b;
        part_a     = {rem_reg, quot_reg[CELL_W-1]};
        bit_a      = (part_a >= divisor);
        part_a_sub = bit_a ? (part_a - divisor) : part_a;
        part_b     = {part_a_sub[POS_W-1:0], quot_reg[CELL_W-2]};
        bit_b      = (part_b >= divisor);
        part_b_sub = bit_b ? (part_b - divisor) : part_b;
        rem_new    = part_b_sub[POS_W-1:0];
        quot_new   = {quot_reg[CELL_W-3:0], bit_a, bit_b};
        step_done  = (step_reg == STEP_W'(DIV_STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DEC_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DEC_IDLE:
            begin
                if (load)
                    state_next = DEC_DIV;
            end
            DEC_DIV:
            begin
                if (step_done && axis_reg == 2'd1)
                    state_next = DEC_HOLD;
            end
            DEC_HOLD:
            begin
                if (take)
                    state_next = DEC_IDLE;
            end
            default:
            begin
                state_next = DEC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DEC_IDLE && load)
        begin
            quot_reg <= home;
            rem_reg  <= '0;
            step_reg <= '0;
            axis_reg <= FIRST_AXIS;
            pos2_reg <= '0;
        end
        else if (state_reg == DEC_DIV)
        begin
            if (!step_done)
            begin
                quot_reg <= quot_new;
                rem_reg  <= rem_new;
                step_reg <= step_reg + 1'b1;
            end
            else if (axis_reg == 2'd2)
            begin
                pos2_reg <= rem_new;
                quot_reg <= quot_new;
                rem_reg  <= '0;
                step_reg <= '0;
                axis_reg <= 2'd1;
            end
            else
            begin
                pos1_reg <= rem_new;
                pos0_reg <= quot_new[POS_W-1:0];
                err_reg  <= (quot_new >= {15'b0, cfg.cells_a});
            end
        end
    end

    assign ready       = (state_reg == DEC_IDLE);
    assign coord.valid = (state_reg == DEC_HOLD);
    assign coord.err   = err_reg;
    assign coord.pos0  = pos0_reg;
    assign coord.pos1  = pos1_reg;
    assign coord.pos2  = pos2_reg;

endmodule

[hw/rtl/pnci_emit.sv]
`timescale 1ns / 1ps

module pnci_emit
    import pnci_pkg::*;
#(
    parameter int DIMENSIONS = 3
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  pnci_cfg_t    cfg,
    input  pnci_coord_t  coord,
    output logic         take,
    output pnci_result_t result
);

    localparam int                TOTAL     = 3 ** DIMENSIONS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TOTAL - 1);
    localparam logic [1:0]        DIG2_INIT = (DIMENSIONS == 3) ? DIGIT_MINUS : DIGIT_ZERO;

    // Sequencer that walks the neighbour offsets of one home cell.
    logic              act_reg;
    logic              err_item_reg;
    logic [1:0]        dig0_reg;
    logic [1:0]        dig1_reg;
    logic [1:0]        dig2_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [POS_W-1:0]  pos0_reg;
    logic [POS_W-1:0]  pos1_reg;
    logic [POS_W-1:0]  pos2_reg;
    logic              is_final;
    logic              carry1;
    logic              carry2;

    // Pipeline stages.
    logic              s1_valid_reg;
    logic              s1_err_reg;
    logic              s1_last_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [POS_W-1:0]  s1_np0_reg;
    logic [POS_W-1:0]  s1_np1_reg;
    logic [POS_W-1:0]  s1_np2_reg;

    logic              s2_valid_reg;
    logic              s2_err_reg;
    logic              s2_last_reg;
    logic [SLOT_W-1:0] s2_slot_reg;
    logic [15:0]       s2_prod_reg;
    logic [POS_W-1:0]  s2_np1_reg;
    logic [POS_W-1:0]  s2_np2_reg;

    logic              s3_valid_reg;
    logic              s3_err_reg;
    logic              s3_last_reg;
    logic [SLOT_W-1:0] s3_slot_reg;
    logic [15:0]       s3_sum_reg;
    logic [POS_W-1:0]  s3_np2_reg;

    logic              s4_valid_reg;
    logic              s4_err_reg;
    logic              s4_last_reg;
    logic [SLOT_W-1:0] s4_slot_reg;
    logic [CELL_W-1:0] s4_prod_reg;
    logic [POS_W-1:0]  s4_np2_reg;

    logic              out_valid_reg;
    logic              out_err_reg;
    logic              out_last_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [CELL_W-1:0] out_cell_reg;

    logic [CFG_W-1:0]  scale;
    logic [16:0]       mul_ab;
    logic [24:0]       mul_c;

    always_comb
    begin
        is_final = err_item_reg || (slot_reg == LAST_SLOT);
        take     = coord.valid && (!act_reg || is_final);
        carry1   = (dig0_reg == DIGIT_PLUS);
        carry2   = carry1 && (dig1_reg == DIGIT_PLUS);
        scale    = (DIMENSIONS == 3) ? cfg.cells_c : 9'd1;
        mul_ab   = s1_np0_reg * cfg.cells_b;
        mul_c    = s3_sum_reg * scale;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= 1'b0;
        else if (take)
            act_reg <= 1'b1;
        else if (is_final)
            act_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            err_item_reg <= coord.err;
            pos0_reg     <= coord.pos0;
            pos1_reg     <= coord.pos1;
            pos2_reg     <= coord.pos2;
            dig0_reg     <= DIGIT_MINUS;
            dig1_reg     <= DIGIT_MINUS;
            dig2_reg     <= DIG2_INIT;
            slot_reg     <= '0;
        end
        else if (act_reg && !is_final)
        begin
            slot_reg <= slot_reg + 1'b1;
            dig0_reg <= carry1 ? DIGIT_MINUS : dig0_reg + 1'b1;
            if (carry1)
                dig1_reg <= carry2 ? DIGIT_MINUS : dig1_reg + 1'b1;
            if (carry2 && DIMENSIONS == 3)
                dig2_reg <= dig2_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= act_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg  <= err_item_reg;
        s1_last_reg <= is_final;
        s1_slot_reg <= slot_reg;
        s1_np0_reg  <= pnci_wrap(pos0_reg, dig0_reg, cfg.cells_a);
        s1_np1_reg  <= pnci_wrap(pos1_reg, dig1_reg, cfg.cells_b);
        s1_np2_reg  <= pnci_wrap(pos2_reg, dig2_reg, cfg.cells_c);

        s2_err_reg  <= s1_err_reg;
        s2_last_reg <= s1_last_reg;
        s2_slot_reg <= s1_slot_reg;
        s2_prod_reg <= mul_ab[15:0];
        s2_np1_reg  <= s1_np1_reg;
        s2_np2_reg  <= s1_np2_reg;

        s3_err_reg  <= s2_err_reg;
        s3_last_reg <= s2_last_reg;
        s3_slot_reg <= s2_slot_reg;
        s3_sum_reg  <= s2_prod_reg + {8'b0, s2_np1_reg};
        s3_np2_reg  <= s2_np2_reg;

        s4_err_reg  <= s3_err_reg;
        s4_last_reg <= s3_last_reg;
        s4_slot_reg <= s3_slot_reg;
        s4_prod_reg <= mul_c[CELL_W-1:0];
        s4_np2_reg  <= s3_np2_reg;

        out_err_reg  <= s4_err_reg;
        out_last_reg <= s4_last_reg;
        out_slot_reg <= s4_slot_reg;
        out_cell_reg <= s4_err_reg ? '0 : (s4_prod_reg + {16'b0, s4_np2_reg});
    end

    assign result.valid  = out_valid_reg;
    assign result.nbr_id = out_cell_reg;
    assign result.slot   = out_slot_reg;
    assign result.err    = out_err_reg;
    assign result.last   = out_last_reg;

endmodule

[hw/rtl/periodic_neighbour_cell_ids.sv]
// The first result follows start through the holding stage, the divider and the emitter pipeline.
// A new home cell can be taken while the last is still being divided or emitted; the rate is
// bounded by the 27 or 9 results on the single output port and the 2-bit-per-cycle divider.
// An out-of-range home cell yields a single error result after the division time.
// Reset (rst_n low, asynchronous) clears all valid flags and state machines and sets each axis to 3.
// Results are strobed for one cycle on result_valid; the receiver cannot stall them.
`timescale 1ns / 1ps

`include "periodic_neighbour_cell_ids_assert.svh"

module periodic_neighbour_cell_ids
    import pnci_pkg::*;
#(
    parameter int DIMENSIONS = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CELL_W-1:0] home_cell,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              result_valid,
    output logic [CELL_W-1:0] nbr_id,
    output logic [SLOT_W-1:0] neighbour_slot,
    output logic              id_error,
    output logic              last
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(3 ** DIMENSIONS - 1);

    // Configuration registers. Values outside 3..256 are clamped on write, so
    // the product of the three axes never exceeds the 24-bit cell number range.
    logic [CFG_W-1:0]  cells_a_reg;
    logic [CFG_W-1:0]  cells_b_reg;
    logic [CFG_W-1:0]  cells_c_reg;
    logic [CFG_W-1:0]  cfg_clamped;
    pnci_cfg_t         cfg;

    // A single input holding stage lets a new transaction be taken while the
    // divider is still working on, or handing over, the previous home cell.
    logic              pend_reg;
    logic [CELL_W-1:0] home_reg;

    logic              dec_ready;
    logic              dec_load;
    logic              take;
    pnci_coord_t       coord;
    pnci_result_t      result;

    // Terms used by the checks at the end of the module.
    logic              chk_err_form;
    logic              chk_tail;
    logic              chk_more;
    logic [SLOT_W-1:0] chk_slot_succ;
    logic              chk_cells;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data < CELLS_MIN)
            cfg_clamped = CELLS_MIN;
        else if (cfg_data > CELLS_MAX)
            cfg_clamped = CELLS_MAX;
        else
            cfg_clamped = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_a_reg <= CELLS_MIN;
            cells_b_reg <= CELLS_MIN;
            cells_c_reg <= CELLS_MIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // A write to an index beyond the register list is dropped.
            unique case (cfg_index)
                CFG_CELLS_A: cells_a_reg <= cfg_clamped;
                CFG_CELLS_B: cells_b_reg <= cfg_clamped;
                CFG_CELLS_C: cells_c_reg <= cfg_clamped;
                default:     ;
            endcase
        end
    end

    assign cfg.cells_a = cells_a_reg;
    assign cfg.cells_b = cells_b_reg;
    assign cfg.cells_c = cells_c_reg;

    // The holding stage fills on an accepted transaction and empties as soon
    // as the divider is free to load it.
    assign busy     = pend_reg;
    assign dec_load = pend_reg && dec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (start && !busy)
            pend_reg <= 1'b1;
        else if (dec_load)
            pend_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            home_reg <= home_cell;
    end

    // The decoder splits the cell number into per-axis coordinates by repeated
    // division, least significant axis first, and flags a number beyond the grid.
    pnci_decode #(
        .DIMENSIONS (DIMENSIONS)
    ) u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .load  (dec_load),
        .home  (home_reg),
        .ready (dec_ready),
        .take  (take),
        .coord (coord)
    );

    // The emitter walks the offsets, one neighbour per cycle, through a
    // five-stage wrap, multiply, add, multiply, add pipeline.
    pnci_emit #(
        .DIMENSIONS (DIMENSIONS)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .coord  (coord),
        .take   (take),
        .result (result)
    );

    assign result_valid   = result.valid;
    assign nbr_id         = result.nbr_id;
    assign neighbour_slot = result.slot;
    assign id_error       = result.err;
    assign last           = result.last;

    // An error result is a lone, zeroed transaction; a neighbour burst runs
    // without gaps and ends on the last slot.
    assign chk_err_form  = last && (nbr_id == '0) && (neighbour_slot == '0);
    assign chk_tail      = result_valid && last && !id_error;
    assign chk_more      = result_valid && !last;
    assign chk_slot_succ = neighbour_slot + 1'b1;
    assign chk_cells     = (cells_a_reg >= CELLS_MIN) && (cells_a_reg <= CELLS_MAX)
                        && (cells_b_reg >= CELLS_MIN) && (cells_b_reg <= CELLS_MAX)
                        && (cells_c_reg >= CELLS_MIN) && (cells_c_reg <= CELLS_MAX);

    `PNCI_ASSERT_IMPLIES(a_error_form, result_valid && id_error, chk_err_form, "bad error result")
    `PNCI_ASSERT_IMPLIES(a_last_slot, chk_tail, neighbour_slot == LAST_SLOT, "wrong final slot")
    `PNCI_ASSERT_NEXT(a_burst, chk_more, result_valid && neighbour_slot == $past(chk_slot_succ), "burst gap")
    `PNCI_ASSERT_HOLDS(a_cells_range, chk_cells, "axis size outside the clamped range")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

// Bench for the periodic neighbour cell block. Home cell numbers are fed
// through the start/busy command port, and the 27 neighbour numbers (or the
// lone error result) that each one yields are checked in order against a
// predictor kept in a small scoreboard class. The grid sizes are changed
// by register writes between phases, but only once the block has gone quiet.
module tb_top;

    import pnci_pkg::*;

    localparam int DIMS        = 3;
    localparam int NEIGHBOURS  = 3 ** DIMS;
    localparam int PHASE_ITEMS = 25;
    localparam int PHASES      = 8;
    // Cycles allowed for the block to run dry before a drain gives up.
    localparam int DRAIN_LIMIT = 4000;
    // Settling time after the last result, well beyond the block's latency.
    localparam int SETTLE      = 40;

    // There is no register behind this index, so a write to it must be dropped.
    localparam logic [1:0] CFG_INDEX_UNUSED = 2'd3;

    typedef struct packed {
        logic [CELL_W-1:0] nbr_id;
        logic [SLOT_W-1:0] slot;
        logic              err;
        logic              tail;
    } neighbour_t;

    // The scoreboard keeps its own copy of the grid sizes, works out the
    // neighbour list for every accepted home cell and compares the strobed
    // results with it, oldest first.
    class neighbour_scoreboard;
        logic [CFG_W-1:0] axis_cells [DIMS];
        neighbour_t       due_q [$];
        int               errors;

        function new();
            foreach (axis_cells[d])
                axis_cells[d] = CELLS_MIN;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        function void set_axis(input logic [1:0] idx, input logic [CFG_W-1:0] data);
            logic [CFG_W-1:0] v;
            if (idx > CFG_CELLS_C)
                return;
            v = data;
            if (v < CELLS_MIN)
                v = CELLS_MIN;
            if (v > CELLS_MAX)
                v = CELLS_MAX;
            axis_cells[idx] = v;
        endfunction

        function int unsigned cell_count();
            int unsigned n;
            n = 1;
            for (int d = 0; d < DIMS; d++)
                n = n * 32'(axis_cells[d]);
            return n;
        endfunction

        function void note_cell(input logic [CELL_W-1:0] home);
            int unsigned pos [DIMS];
            int unsigned rest;
            int unsigned digits;
            int unsigned id;
            int unsigned np;
            int unsigned s;
            neighbour_t  n;
            if (32'(home) >= cell_count())
            begin
                n = '{nbr_id: '0, slot: '0, err: 1'b1, tail: 1'b1};
                due_q.push_back(n);
                return;
            end
            rest = 32'(home);
            for (int d = DIMS - 1; d >= 0; d--)
            begin
                s      = 32'(axis_cells[d]);
                pos[d] = rest % s;
                rest   = rest / s;
            end
            for (int k = 0; k < NEIGHBOURS; k++)
            begin
                digits = k;
                id     = 0;
                for (int d = 0; d < DIMS; d++)
                begin
                    s      = 32'(axis_cells[d]);
                    np     = pos[d] + digits % 3;
                    digits = digits / 3;
                    if (np == 0)
                        np = s - 1;
                    else
                        np = np - 1;
                    if (np >= s)
                        np = np - s;
                    id = id * s + np;
                end
                n.nbr_id = id[CELL_W-1:0];
                n.slot   = k[SLOT_W-1:0];
                n.err    = 1'b0;
                n.tail   = (k == NEIGHBOURS - 1);
                due_q.push_back(n);
            end
        endfunction

        task check_result(input logic [CELL_W-1:0] got_id, input logic [SLOT_W-1:0] slot,
                          input logic err, input logic tail);
            neighbour_t n;
            if (due_q.size() == 0)
            begin
                report($sformatf("result id %0d slot %0d with nothing expected", got_id, slot));
                return;
            end
            n = due_q.pop_front();
            if (got_id !== n.nbr_id)
                report($sformatf("nbr_id %0d, expected %0d", got_id, n.nbr_id));
            if (slot !== n.slot)
                report($sformatf("neighbour_slot %0d, expected %0d", slot, n.slot));
            if (err !== n.err)
                report($sformatf("id_error %b, expected %b", err, n.err));
            if (tail !== n.tail)
                report($sformatf("last %b, expected %b", tail, n.tail));
        endtask

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              start          = 1'b0;
    logic              busy;
    logic [CELL_W-1:0] home_cell      = '0;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index      = CFG_CELLS_A;
    logic [CFG_W-1:0]  cfg_data       = '0;
    logic              result_valid;
    logic [CELL_W-1:0] nbr_id;
    logic [SLOT_W-1:0] neighbour_slot;
    logic              id_error;
    logic              last;

    neighbour_scoreboard sb = new();

    always #6 clk = ~clk;

    periodic_neighbour_cell_ids #(
        .DIMENSIONS (DIMS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .home_cell      (home_cell),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .nbr_id         (nbr_id),
        .neighbour_slot (neighbour_slot),
        .id_error       (id_error),
        .last           (last)
    );

    // Results cannot be held off, so every strobed cycle is a transaction
    // that goes straight to the scoreboard. The outputs are read in the
    // active region of the edge, that is, with the values the edge closes.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(nbr_id, neighbour_slot, id_error, last);
    end

    // Offers a home cell and returns at the edge that accepts it. Start is
    // left high so that a following transaction can be offered back to back
    // without lowering and raising it in the same time step.
    task automatic send_cell(input logic [CELL_W-1:0] v);
        start     <= 1'b1;
        home_cell <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_cell(v);
    endtask

    // Drops start for a number of cycles, with noise on the idle data lines.
    task automatic idle_gap(input int unsigned cycles);
        start     <= 1'b0;
        home_cell <= CELL_W'($urandom);
        repeat (cycles)
            @(posedge clk);
    endtask

    // One register write transaction. As with start, valid stays high on
    // return and the caller lowers it once the whole batch has gone in.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_axis(idx, data);
    endtask

    // Holds off new work until every expected result has arrived and the
    // block is no longer busy, then lets it settle. Anything still owed
    // after the limit is reported and dropped.
    task automatic drain();
        int unsigned waited;
        waited = 0;
        start <= 1'b0;
        while ((sb.pending() != 0 || busy) && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
        begin
            sb.report($sformatf("%0d results never arrived", sb.pending()));
            sb.due_q.delete();
        end
        repeat (SETTLE)
            @(posedge clk);
    endtask

    // Grid sizes lean on the extremes, and now and then fall outside the
    // legal range so that the clamping on the write path is exercised.
    function automatic logic [CFG_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(9, 0);
        case (r)
            0:       return CELLS_MIN;
            1:       return CELLS_MAX;
            2:       return CFG_W'($urandom_range(2, 0));
            3:       return CFG_W'($urandom_range(511, 257));
            default: return CFG_W'($urandom_range(256, 3));
        endcase
    endfunction

    // Most home cells lie inside the grid; some sit on its corners and a
    // few lie past the end of it, which must give the single error result.
    function automatic logic [CELL_W-1:0] pick_home();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(99, 0);
        n = sb.cell_count();
        if (r < 12 && n < (1 << CELL_W))
            return CELL_W'($urandom_range((1 << CELL_W) - 1, n));
        if (r < 16)
            return '0;
        if (r < 20)
            return CELL_W'(n - 1);
        return CELL_W'($urandom_range(n - 1, 0));
    endfunction

    initial
    begin
        int unsigned idle_pct;
        int unsigned gap;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cells on the 3 x 3 x 3 grid that reset leaves behind.
        // Every axis has exactly three cells, so the neighbours of a cell
        // are the 27 cells of the grid, each appearing exactly once.
        send_cell(24'd0);
        send_cell(24'd13);
        send_cell(24'd26);
        send_cell(24'd27);
        send_cell(24'hFFFFFF);
        drain();

        // The largest grid: every 24-bit number is a valid home cell, and
        // writes above the maximum must be clamped down to it.
        write_reg(CFG_CELLS_A, 9'd511);
        write_reg(CFG_CELLS_B, 9'd256);
        write_reg(CFG_CELLS_C, 9'd300);
        cfg_valid <= 1'b0;
        send_cell(24'd0);
        send_cell(24'hFFFFFF);
        send_cell(24'hAAAAAA);
        send_cell(24'h555555);
        send_cell(24'h010203);
        drain();

        // A mixed grid reached through clamping at both ends, plus a write
        // to the unused index, which must leave the sizes untouched.
        write_reg(CFG_CELLS_A, 9'd0);
        write_reg(CFG_CELLS_B, 9'd257);
        write_reg(CFG_CELLS_C, 9'd2);
        write_reg(CFG_INDEX_UNUSED, 9'd7);
        cfg_valid <= 1'b0;
        send_cell(24'd0);
        send_cell(CELL_W'(sb.cell_count() - 1));
        send_cell(CELL_W'(sb.cell_count()));
        send_cell(24'h800000);
        drain();

        // Random phases. Each starts from a quiet block with fresh sizes;
        // the sender idles often in the first phases, more often in the
        // middle ones and not at all at the end.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_reg(CFG_CELLS_A, pick_size());
            write_reg(CFG_CELLS_B, pick_size());
            write_reg(CFG_CELLS_C, pick_size());
            if ($urandom_range(3, 0) == 0)
                write_reg(CFG_INDEX_UNUSED, CFG_W'($urandom));
            cfg_valid <= 1'b0;
            if (ph < 3)
                idle_pct = 21;
            else if (ph < 6)
                idle_pct = 50;
            else
                idle_pct = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99, 0) < idle_pct)
                begin
                    // Mostly short gaps, with the odd long one so that a
                    // pause lands on every stage of the block's work.
                    if ($urandom_range(7, 0) == 0)
                        gap = $urandom_range(60, 10);
                    else
                        gap = $urandom_range(6, 1);
                    idle_gap(gap);
                end
                send_cell(pick_home());
            end
        end

        drain();
        if (sb.errors == 0)
            $display("[periodic_neighbour_cell_ids] OK");
        else
            $display("[periodic_neighbour_cell_ids] ERROR");
        $finish;
    end

    // Guard against a block that stops answering altogether.
    initial
    begin
        #5000000;
        $display("[periodic_neighbour_cell_ids] ERROR");
        $finish;
    end

endmodule
